// ----- rtl/lss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap sensor statistics package
// Widths, channel codes, sentinels and the command and status types that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int CadW  = 8;
  localparam int HrW   = 8;
  localparam int ElevW = 18;
  localparam int SpdW  = 17;
  localparam int ValW  = 18;
  localparam int AvgW  = 17;
  localparam int SumW  = 34;
  localparam int CntW  = 16;
  localparam int TotW  = 32;
  localparam int ChW   = 2;
  localparam int NumCh = 4;
  localparam int NumSum = 3;

  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam logic [CntW-1:0] MAX_SAMPLES = 16'hFFFF;

  localparam logic signed [ValW-1:0] NONE_MAX = 18'sh20000;
  localparam logic signed [ValW-1:0] NONE_MIN = 18'sh1FFFF;

  localparam logic [ChW-1:0] CH_CAD  = 2'd0;
  localparam logic [ChW-1:0] CH_HR   = 2'd1;
  localparam logic [ChW-1:0] CH_SPD  = 2'd2;
  localparam logic [ChW-1:0] CH_ELEV = 2'd3;

  typedef struct packed {
    logic           update;
    logic           div_start;
    logic           load;
    logic           clear;
    logic [ChW-1:0] ch;
  } lss_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } lss_status_t;

endpackage

// ----- rtl/lss_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap sensor statistics divider
// Restoring divider that produces one quotient bit per cycle for the lap
// averages. The done flag stays high until the next start.
// ----------------------------------------------------------------------------
module lss_div
  import lss_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SumW-1:0] dividend,
  input  logic [CntW-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic [AvgW-1:0] quotient
);

  logic [CntW-1:0]    rem_r, rem_nxt;
  logic [SumW-1:0]    quo_r, quo_nxt;
  logic [CntW-1:0]    dsr_r;
  logic [DivCntW-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [CntW:0]      trial;
  logic [CntW:0]      diff;

  always_comb begin
    trial = {rem_r, quo_r[SumW-1]};
    diff  = trial - {1'b0, dsr_r};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[CntW-1:0];
      quo_nxt = {quo_r[SumW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[CntW-1:0];
      quo_nxt = {quo_r[SumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DivCntW'(DivSteps);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DivCntW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r[AvgW-1:0];

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not go busy after start");

endmodule

// ----- rtl/lss_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap sensor statistics datapath
// Running extrema, sums, sample count and elevation totals, the shared
// divider for the averages and the output register.
// ----------------------------------------------------------------------------
module lss_dpath
  import lss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lss_cmd_t               cmd,
  output lss_status_t            status,
  input  logic [CadW-1:0]        in_cadence,
  input  logic [HrW-1:0]         in_heart_rate,
  input  logic signed [ElevW-1:0] in_elevation,
  input  logic [SpdW-1:0]        in_speed,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ChW-1:0]         out_channel,
  output logic signed [ValW-1:0] out_maximum,
  output logic signed [ValW-1:0] out_minimum,
  output logic [AvgW-1:0]        out_average,
  output logic [TotW-1:0]        out_gain,
  output logic [TotW-1:0]        out_loss,
  output logic                   out_last
);

  logic signed [ValW-1:0] max_r [NumCh];
  logic signed [ValW-1:0] min_r [NumCh];
  logic [SumW-1:0]        sum_r [NumSum];
  logic [CntW-1:0]        count_r;
  logic [TotW-1:0]        gain_r;
  logic [TotW-1:0]        loss_r;
  logic signed [ElevW-1:0] prev_r;
  logic                   have_prev_r;

  logic signed [ValW-1:0] vals [NumCh];
  logic                   use_min [NumCh];
  logic signed [ElevW:0]  step;
  logic [ElevW:0]         step_mag;
  logic [TotW:0]          gain_sum;
  logic [TotW:0]          loss_sum;
  logic                   room;

  logic                   div_busy;
  logic                   div_done;
  logic [AvgW-1:0]        div_quo;

  logic                   out_valid_r;
  logic [ChW-1:0]         out_channel_r;
  logic signed [ValW-1:0] out_max_r;
  logic signed [ValW-1:0] out_min_r;
  logic [AvgW-1:0]        out_avg_r;
  logic [TotW-1:0]        out_gain_r;
  logic [TotW-1:0]        out_loss_r;
  logic                   out_last_r;
  logic signed [ValW-1:0] sel_max;
  logic signed [ValW-1:0] sel_min;

  always_comb begin
    vals[0]    = $signed({{(ValW-CadW){1'b0}}, in_cadence});
    vals[1]    = $signed({{(ValW-HrW){1'b0}}, in_heart_rate});
    vals[2]    = $signed({{(ValW-SpdW){1'b0}}, in_speed});
    vals[3]    = in_elevation;
    use_min[0] = 1'b1;
    use_min[1] = (in_heart_rate != '0);
    use_min[2] = 1'b1;
    use_min[3] = 1'b1;
    room       = (count_r != MAX_SAMPLES);
    step       = {in_elevation[ElevW-1], in_elevation} - {prev_r[ElevW-1], prev_r};
    step_mag   = step[ElevW] ? (~step + 1'b1) : step;
    gain_sum   = {1'b0, gain_r} + {{(TotW-ElevW){1'b0}}, step_mag};
    loss_sum   = {1'b0, loss_r} + {{(TotW-ElevW){1'b0}}, step_mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < NumCh; i++) begin
        max_r[i] <= NONE_MAX;
        min_r[i] <= NONE_MIN;
      end
      for (int i = 0; i < NumSum; i++) begin
        sum_r[i] <= '0;
      end
      count_r <= '0;
      gain_r  <= '0;
      loss_r  <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < NumCh; i++) begin
        if (vals[i] > max_r[i]) begin
          max_r[i] <= vals[i];
        end
        if (use_min[i] && (vals[i] < min_r[i])) begin
          min_r[i] <= vals[i];
        end
      end
      if (room) begin
        sum_r[0] <= sum_r[0] + {{(SumW-CadW){1'b0}}, in_cadence};
        sum_r[1] <= sum_r[1] + {{(SumW-HrW){1'b0}}, in_heart_rate};
        sum_r[2] <= sum_r[2] + {{(SumW-SpdW){1'b0}}, in_speed};
        count_r  <= count_r + 1'b1;
      end
      if (have_prev_r && (step != '0)) begin
        if (!step[ElevW]) begin
          gain_r <= gain_sum[TotW] ? '1 : gain_sum[TotW-1:0];
        end else begin
          loss_r <= loss_sum[TotW] ? '1 : loss_sum[TotW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.update) begin
      prev_r      <= in_elevation;
      have_prev_r <= 1'b1;
    end
  end

  lss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r[cmd.ch[1:0] == CH_ELEV ? CH_SPD : cmd.ch]),
    .divisor  (count_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    sel_max = max_r[cmd.ch];
    sel_min = min_r[cmd.ch];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_channel_r <= cmd.ch;
      out_max_r     <= (sel_max == NONE_MAX) ? '0 : sel_max;
      out_min_r     <= (sel_min == NONE_MIN) ? '0 : sel_min;
      out_avg_r     <= ((cmd.ch == CH_ELEV) || (count_r == '0)) ? '0 : div_quo;
      out_gain_r    <= (cmd.ch == CH_ELEV) ? gain_r : '0;
      out_loss_r    <= (cmd.ch == CH_ELEV) ? loss_r : '0;
      out_last_r    <= (cmd.ch == CH_ELEV);
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_maximum = out_max_r;
  assign out_minimum = out_min_r;
  assign out_average = out_avg_r;
  assign out_gain    = out_gain_r;
  assign out_loss    = out_loss_r;
  assign out_last    = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending beat");

  a_update_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !div_busy)
    else $error("sample folded in while the divider is busy");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && (cmd.ch != CH_ELEV)) |-> div_done)
    else $error("average loaded before the divider finished");

endmodule

// ----- rtl/lss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap sensor statistics controller
// Accepts samples and, at the end of a lap, sequences the three divisions
// and the four result beats, clearing the lap with the elevation beat.
// ----------------------------------------------------------------------------
module lss_ctrl
  import lss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last_of_lap,
  output logic        in_stall,
  output lss_cmd_t    cmd,
  input  lss_status_t status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_ELEV  = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [ChW-1:0] ch_r, ch_nxt;
  logic           accept;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    in_stall      = (state_r != S_IDLE);
    accept        = in_valid && !in_stall;
    cmd.update    = accept;
    cmd.div_start = 1'b0;
    cmd.load      = 1'b0;
    cmd.clear     = 1'b0;
    cmd.ch        = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_last_of_lap) begin
          state_nxt = S_START;
          ch_nxt    = CH_CAD;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done && status.out_free) begin
          cmd.load  = 1'b1;
          ch_nxt    = ch_r + 1'b1;
          state_nxt = (ch_r == CH_SPD) ? S_ELEV : S_START;
        end
      end
      S_ELEV: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= CH_CAD;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  a_lap_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_of_lap) |=> in_stall)
    else $error("input not stalled after a lap end");

  a_clear_on_elev: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (cmd.load && (cmd.ch == CH_ELEV)))
    else $error("lap cleared outside the elevation beat");

endmodule

// ----- rtl/lap_sensor_statistics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap sensor statistics
// Per-lap running maximum, minimum and mean of cadence, heart rate and
// speed, and elevation extrema with saturating gain and loss totals.
// ----------------------------------------------------------------------------
// One input beat carries one sensor sample. Both channels use valid and
// stall; a beat moves on a clock edge with valid high and stall low.
// A sample without the end-of-lap flag is folded in at the edge it is
// accepted, so such samples may arrive every cycle while in_stall is low.
// A sample with the flag is folded in and then the block holds in_stall
// high while it produces four result beats: cadence, heart rate, speed and
// elevation, the last one marked by out_last. Each average takes a pass of
// the shared one-bit-per-cycle divider, and the block takes input again
// once the elevation beat is loaded. The elevation beat sits in the output
// register while the next lap already starts. When the receiver stalls,
// the current beat holds and the sequence waits.
// Reset (synchronous, active low) clears all lap values, the previous
// elevation and any pending result beat.
// ----------------------------------------------------------------------------
module lap_sensor_statistics
  import lss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CadW-1:0]         in_cadence,
  input  logic [HrW-1:0]          in_heart_rate,
  input  logic signed [ElevW-1:0] in_elevation,
  input  logic [SpdW-1:0]         in_speed,
  input  logic                    in_last_of_lap,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ChW-1:0]          out_channel,
  output logic signed [ValW-1:0]  out_maximum,
  output logic signed [ValW-1:0]  out_minimum,
  output logic [AvgW-1:0]         out_average,
  output logic [TotW-1:0]         out_gain,
  output logic [TotW-1:0]         out_loss,
  output logic                    out_last
);

  lss_cmd_t    cmd;
  lss_status_t status;

  lss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_of_lap (in_last_of_lap),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .status         (status)
  );

  lss_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_cadence    (in_cadence),
    .in_heart_rate (in_heart_rate),
    .in_elevation  (in_elevation),
    .in_speed      (in_speed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .out_maximum   (out_maximum),
    .out_minimum   (out_minimum),
    .out_average   (out_average),
    .out_gain      (out_gain),
    .out_loss      (out_loss),
    .out_last      (out_last)
  );

endmodule

// ----- bench/lap_summary_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap summary checker
// Watches the sample and summary channels of the lap sensor statistics
// block. Every accepted sample beat is folded into a local copy of the lap
// state. A lap end queues the four summary beats that the lap must produce.
// Each accepted summary beat is compared field by field with the oldest
// queued beat. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module lap_summary_checker
  import lss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [CadW-1:0]         in_cadence,
  input  logic [HrW-1:0]          in_heart_rate,
  input  logic signed [ElevW-1:0] in_elevation,
  input  logic [SpdW-1:0]         in_speed,
  input  logic                    in_last_of_lap,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [ChW-1:0]          out_channel,
  input  logic signed [ValW-1:0]  out_maximum,
  input  logic signed [ValW-1:0]  out_minimum,
  input  logic [AvgW-1:0]         out_average,
  input  logic [TotW-1:0]         out_gain,
  input  logic [TotW-1:0]         out_loss,
  input  logic                    out_last,
  output int                      failures,
  output int                      summaries_due
);

  typedef struct packed {
    logic [ChW-1:0]         channel;
    logic signed [ValW-1:0] maximum;
    logic signed [ValW-1:0] minimum;
    logic [AvgW-1:0]        average;
    logic [TotW-1:0]        gain;
    logic [TotW-1:0]        loss;
    logic                   last;
  } summary_beat_t;

  logic signed [ValW-1:0]  lap_max [NumCh];
  logic signed [ValW-1:0]  lap_min [NumCh];
  logic [SumW-1:0]         lap_sum [NumSum];
  logic [CntW-1:0]         lap_count;
  logic [TotW-1:0]         lap_gain;
  logic [TotW-1:0]         lap_loss;
  logic signed [ElevW-1:0] prior_elevation;
  logic                    prior_valid;
  summary_beat_t           summary_q [$];

  initial begin
    failures = 0;
    summaries_due = 0;
  end

  task automatic report_mismatch(input string what);
    if (failures < 40) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    failures++;
  endtask

  task automatic clear_lap();
    for (int i = 0; i < NumCh; i++) begin
      lap_max[i] = NONE_MAX;
      lap_min[i] = NONE_MIN;
    end
    for (int i = 0; i < NumSum; i++) begin
      lap_sum[i] = '0;
    end
    lap_count = '0;
    lap_gain = '0;
    lap_loss = '0;
  endtask

  task automatic track_extrema(input logic [ChW-1:0] ch, input logic signed [ValW-1:0] v,
                               input logic use_min);
    if (v > lap_max[ch]) begin
      lap_max[ch] = v;
    end
    if (use_min && v < lap_min[ch]) begin
      lap_min[ch] = v;
    end
  endtask

  function automatic logic [TotW-1:0] saturating_add(input logic [TotW-1:0] a,
                                                     input logic [TotW:0] b);
    logic [TotW+1:0] s;
    s = a + b;
    return (s > {2'b00, {TotW{1'b1}}}) ? {TotW{1'b1}} : s[TotW-1:0];
  endfunction

  function automatic logic [AvgW-1:0] lap_mean(input logic [ChW-1:0] ch);
    logic [SumW-1:0] q;
    if (lap_count == '0) begin
      return '0;
    end
    q = lap_sum[ch] / SumW'(lap_count);
    return q[AvgW-1:0];
  endfunction

  function automatic summary_beat_t summary_beat(input logic [ChW-1:0] ch,
                                                 input logic [AvgW-1:0] avg,
                                                 input logic [TotW-1:0] g,
                                                 input logic [TotW-1:0] l);
    summary_beat_t b;
    b.channel = ch;
    b.maximum = (lap_max[ch] == NONE_MAX) ? '0 : lap_max[ch];
    b.minimum = (lap_min[ch] == NONE_MIN) ? '0 : lap_min[ch];
    b.average = avg;
    b.gain = g;
    b.loss = l;
    b.last = (ch == CH_ELEV);
    return b;
  endfunction

  task automatic fold_sample();
    int step;
    track_extrema(CH_CAD, ValW'(in_cadence), 1'b1);
    track_extrema(CH_HR, ValW'(in_heart_rate), in_heart_rate != '0);
    track_extrema(CH_SPD, ValW'(in_speed), 1'b1);
    track_extrema(CH_ELEV, in_elevation, 1'b1);
    if (lap_count < MAX_SAMPLES) begin
      lap_sum[CH_CAD] += SumW'(in_cadence);
      lap_sum[CH_HR] += SumW'(in_heart_rate);
      lap_sum[CH_SPD] += SumW'(in_speed);
      lap_count++;
    end
    if (prior_valid) begin
      step = int'(in_elevation) - int'(prior_elevation);
      if (step > 0) begin
        lap_gain = saturating_add(lap_gain, (TotW+1)'(step));
      end else if (step < 0) begin
        lap_loss = saturating_add(lap_loss, (TotW+1)'(-step));
      end
    end
    prior_elevation = in_elevation;
    prior_valid = 1'b1;
    if (in_last_of_lap) begin
      summary_q.push_back(summary_beat(CH_CAD, lap_mean(CH_CAD), '0, '0));
      summary_q.push_back(summary_beat(CH_HR, lap_mean(CH_HR), '0, '0));
      summary_q.push_back(summary_beat(CH_SPD, lap_mean(CH_SPD), '0, '0));
      summary_q.push_back(summary_beat(CH_ELEV, '0, lap_gain, lap_loss));
      clear_lap();
    end
  endtask

  always @(posedge clk) begin : watch
    summary_beat_t got;
    summary_beat_t want;
    if (!rst_n) begin
      clear_lap();
      prior_elevation = '0;
      prior_valid = 1'b0;
      summary_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        fold_sample();
      end
      if (out_valid && !out_stall) begin
        got = '{channel: out_channel, maximum: out_maximum, minimum: out_minimum,
                average: out_average, gain: out_gain, loss: out_loss, last: out_last};
        if (summary_q.size() == 0) begin
          report_mismatch($sformatf("summary beat for channel %0d with none expected",
                                    got.channel));
        end else begin
          want = summary_q.pop_front();
          if (got.channel !== want.channel)
            report_mismatch($sformatf("channel %0d, expected %0d", got.channel, want.channel));
          if (got.maximum !== want.maximum)
            report_mismatch($sformatf("channel %0d maximum %0d, expected %0d",
                                      want.channel, got.maximum, want.maximum));
          if (got.minimum !== want.minimum)
            report_mismatch($sformatf("channel %0d minimum %0d, expected %0d",
                                      want.channel, got.minimum, want.minimum));
          if (got.average !== want.average)
            report_mismatch($sformatf("channel %0d average %0d, expected %0d",
                                      want.channel, got.average, want.average));
          if (got.gain !== want.gain)
            report_mismatch($sformatf("channel %0d gain %0d, expected %0d",
                                      want.channel, got.gain, want.gain));
          if (got.loss !== want.loss)
            report_mismatch($sformatf("channel %0d loss %0d, expected %0d",
                                      want.channel, got.loss, want.loss));
          if (got.last !== want.last)
            report_mismatch($sformatf("channel %0d last %0b, expected %0b",
                                      want.channel, got.last, want.last));
        end
      end
    end
    summaries_due = summary_q.size();
  end

endmodule

// ----- bench/tb_lap_sensor_statistics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap sensor statistics testbench
// Feeds directed laps and random laps under several idle and stall
// patterns. A separate checker predicts and compares every summary beat;
// this top drives the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_lap_sensor_statistics;
  import lss_pkg::*;

  localparam int ElevLo      = -10000;
  localparam int ElevHi      = 100000;
  localparam int SpdHi       = 100000;
  localparam int PhaseItems  = 75;
  localparam int DrainCycles = 300;
  localparam int CycleLimit  = 2000000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CadW-1:0]         in_cadence = '0;
  logic [HrW-1:0]          in_heart_rate = '0;
  logic signed [ElevW-1:0] in_elevation = '0;
  logic [SpdW-1:0]         in_speed = '0;
  logic                    in_last_of_lap = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ChW-1:0]          out_channel;
  logic signed [ValW-1:0]  out_maximum;
  logic signed [ValW-1:0]  out_minimum;
  logic [AvgW-1:0]         out_average;
  logic [TotW-1:0]         out_gain;
  logic [TotW-1:0]         out_loss;
  logic                    out_last;

  int failures;
  int summaries_due;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int last_sent_elevation = 0;
  int cycle_count = 0;

  lap_sensor_statistics DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cadence     (in_cadence),
    .in_heart_rate  (in_heart_rate),
    .in_elevation   (in_elevation),
    .in_speed       (in_speed),
    .in_last_of_lap (in_last_of_lap),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_maximum    (out_maximum),
    .out_minimum    (out_minimum),
    .out_average    (out_average),
    .out_gain       (out_gain),
    .out_loss       (out_loss),
    .out_last       (out_last)
  );

  lap_summary_checker summary_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cadence     (in_cadence),
    .in_heart_rate  (in_heart_rate),
    .in_elevation   (in_elevation),
    .in_speed       (in_speed),
    .in_last_of_lap (in_last_of_lap),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_maximum    (out_maximum),
    .out_minimum    (out_minimum),
    .out_average    (out_average),
    .out_gain       (out_gain),
    .out_loss       (out_loss),
    .out_last       (out_last),
    .failures       (failures),
    .summaries_due  (summaries_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL lap_sensor_statistics");
      $finish;
    end
  end

  task automatic send_sample(input logic [CadW-1:0] cad, input logic [HrW-1:0] hr,
                             input int elev, input logic [SpdW-1:0] spd, input logic lap_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cadence <= cad;
    in_heart_rate <= hr;
    in_elevation <= ElevW'(elev);
    in_speed <= spd;
    in_last_of_lap <= lap_end;
    last_sent_elevation = elev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_sample();
    int elev;
    int pick;
    logic [CadW-1:0] cad;
    logic [HrW-1:0] hr;
    logic [SpdW-1:0] spd;
    pick = $urandom_range(7);
    if (pick == 0) begin
      elev = $urandom_range(1) ? ElevHi : ElevLo;
    end else if (pick < 5) begin
      elev = last_sent_elevation + int'($urandom_range(1000)) - 500;
      if (elev > ElevHi) elev = ElevHi;
      if (elev < ElevLo) elev = ElevLo;
    end else begin
      elev = int'($urandom_range(ElevHi - ElevLo)) + ElevLo;
    end
    if ($urandom_range(9) == 0) cad = $urandom_range(1) ? {CadW{1'b1}} : '0;
    else cad = CadW'($urandom_range(255));
    if ($urandom_range(3) == 0) hr = '0;
    else hr = HrW'($urandom_range(255));
    if ($urandom_range(9) == 0) spd = $urandom_range(1) ? SpdW'(SpdHi) : '0;
    else spd = SpdW'($urandom_range(SpdHi));
    send_sample(cad, hr, elev, spd, $urandom_range(5) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed laps: field extremes, all-zero and mixed heart rate, flat and
    // falling elevation, single-sample laps, and alternating bit patterns.
    send_sample(8'd0, 8'd0, ElevLo, 17'd0, 1'b1);
    send_sample(8'd255, 8'd255, ElevHi, 17'(SpdHi), 1'b0);
    send_sample(8'd0, 8'd1, ElevLo, 17'd0, 1'b1);
    send_sample(8'd10, 8'd0, ElevLo, 17'd500, 1'b0);
    send_sample(8'd20, 8'd200, -9000, 17'd700, 1'b0);
    send_sample(8'd30, 8'd0, -9500, 17'd900, 1'b0);
    send_sample(8'd40, 8'd60, -9500, 17'd1100, 1'b1);
    send_sample(8'd1, 8'd0, 0, 17'd1, 1'b1);
    send_sample(8'd2, 8'd2, ElevHi, 17'd2, 1'b1);
    send_sample(8'd3, 8'd0, ElevLo, 17'd3, 1'b1);
    send_sample(8'hAA, 8'hAA, 17'h0AAAA, 17'h0AAAA, 1'b0);
    send_sample(8'h55, 8'h55, 17'h15555, 17'h15555, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 87;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct = 17;
        end
      endcase
      repeat (PhaseItems) send_random_sample();
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (summaries_due != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (failures == 0 && summaries_due == 0) begin
      $display("PASS lap_sensor_statistics");
    end else begin
      $display("FAIL lap_sensor_statistics");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lss_pkg.sv
rtl/lss_div.sv
rtl/lss_dpath.sv
rtl/lss_ctrl.sv
rtl/lap_sensor_statistics.sv
bench/lap_summary_checker.sv
bench/tb_lap_sensor_statistics.sv
